@@ hdl/apr_pkg.sv @@
// apr_pkg: shared constants for the aabb push-out resolver
// push codes, register indexes and the fixed size width; no dependencies
package apr_pkg;

	localparam int SIZE_BITS = 13;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [3:0] {
		PUSH_NONE       = 4'd0,
		PUSH_UP         = 4'd1,
		PUSH_RIGHT      = 4'd2,
		PUSH_DOWN       = 4'd3,
		PUSH_LEFT       = 4'd4,
		PUSH_UP_LEFT    = 4'd5,
		PUSH_DOWN_LEFT  = 4'd6,
		PUSH_UP_RIGHT   = 4'd7,
		PUSH_DOWN_RIGHT = 4'd8
	} push_code_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SOLID_X = 3'd0,
		REG_SOLID_Y = 3'd1,
		REG_SOLID_W = 3'd2,
		REG_SOLID_H = 3'd3
	} reg_index_t;

endpackage

@@ hdl/apr_cfg_regs.sv @@
// apr_cfg_regs: solid box position and size registers
// write-only port decoded by register index; uses apr_pkg
module apr_cfg_regs #(
	parameter int COORD_BITS = 16,
	parameter int CFG_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [apr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [CFG_BITS-1:0]                 cfg_data,
	output logic signed [COORD_BITS-1:0]        solid_x,
	output logic signed [COORD_BITS-1:0]        solid_y,
	output logic [apr_pkg::SIZE_BITS-1:0]       solid_w,
	output logic [apr_pkg::SIZE_BITS-1:0]       solid_h
);
	import apr_pkg::*;

	logic signed [COORD_BITS-1:0] solid_x_q, solid_y_q;
	logic [SIZE_BITS-1:0]         solid_w_q, solid_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solid_x_q <= '0;
			solid_y_q <= '0;
			solid_w_q <= SIZE_BITS'(1);
			solid_h_q <= SIZE_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOLID_X: solid_x_q <= cfg_data[COORD_BITS-1:0];
				REG_SOLID_Y: solid_y_q <= cfg_data[COORD_BITS-1:0];
				REG_SOLID_W: solid_w_q <= cfg_data[SIZE_BITS-1:0];
				REG_SOLID_H: solid_h_q <= cfg_data[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign solid_x = solid_x_q;
	assign solid_y = solid_y_q;
	assign solid_w = solid_w_q;
	assign solid_h = solid_h_q;

endmodule

@@ hdl/apr_resolve.sv @@
// apr_resolve: penetration depths, push selection and push targets
// purely combinational; uses apr_pkg
module apr_resolve #(
	parameter int COORD_BITS = 16
) (
	input  logic signed [COORD_BITS-1:0]    solid_x,
	input  logic signed [COORD_BITS-1:0]    solid_y,
	input  logic [apr_pkg::SIZE_BITS-1:0]   solid_w,
	input  logic [apr_pkg::SIZE_BITS-1:0]   solid_h,
	input  logic signed [COORD_BITS-1:0]    mx,
	input  logic signed [COORD_BITS-1:0]    my,
	input  logic signed [COORD_BITS-1:0]    px,
	input  logic signed [COORD_BITS-1:0]    py,
	input  logic [apr_pkg::SIZE_BITS-1:0]   mw,
	input  logic [apr_pkg::SIZE_BITS-1:0]   mh,
	input  logic                            pushable,
	output logic signed [COORD_BITS:0]      nx,
	output logic signed [COORD_BITS:0]      ny,
	output apr_pkg::push_code_t             code
);
	import apr_pkg::*;

	localparam int DW = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
	localparam int VW = COORD_BITS + 2;
	localparam logic signed [DW-1:0] ONE = DW'(1);

	logic signed [DW-1:0] mx_e, my_e, sx_e, sy_e, mw_e, mh_e, sw_e, sh_e;
	logic signed [DW-1:0] t, r, b, l;
	logic signed [VW-1:0] dx, dy, dsum, ddif;
	logic signed [DW-1:0] up_y, down_y, left_x, right_x;
	logic win_t, win_r, win_b, win_l, tie_lt, tie_lb, tie_rt, tie_rb;
	logic move_y_up, move_y_down, move_x_left, move_x_right;

	always_comb begin
		mx_e = DW'(mx);
		my_e = DW'(my);
		sx_e = DW'(solid_x);
		sy_e = DW'(solid_y);
		mw_e = DW'($signed({1'b0, mw}));
		mh_e = DW'($signed({1'b0, mh}));
		sw_e = DW'($signed({1'b0, solid_w}));
		sh_e = DW'($signed({1'b0, solid_h}));

		t = my_e + mh_e - ONE - sy_e;
		r = sx_e + sw_e - ONE - mx_e;
		b = sy_e + sh_e - ONE - my_e;
		l = mx_e + mw_e - ONE - sx_e;

		dx   = VW'(mx) - VW'(px);
		dy   = VW'(my) - VW'(py);
		dsum = dx + dy;
		ddif = dx - dy;

		win_t  = (t > 0) && (t < r) && (t < b) && (t < l);
		win_r  = (r > 0) && (r < t) && (r < b) && (r < l);
		win_b  = (b > 0) && (b < r) && (b < t) && (b < l);
		win_l  = (l > 0) && (l < r) && (l < b) && (l < t);
		tie_lt = (l > 0) && (l == t) && (l < r) && (l < b);
		tie_lb = (l > 0) && (l == b) && (l < r) && (l < t);
		tie_rt = (r > 0) && (r == t) && (r < l) && (r < b);
		tie_rb = (r > 0) && (r == b) && (r < l) && (r < t);

		code = PUSH_NONE;
		if (!pushable) begin
			code = PUSH_NONE;
		end else if (win_t) begin
			code = PUSH_UP;
		end else if (win_r) begin
			code = PUSH_RIGHT;
		end else if (win_b) begin
			code = PUSH_DOWN;
		end else if (win_l) begin
			code = PUSH_LEFT;
		end else if (tie_lt) begin
			code = (ddif < 0) ? PUSH_UP : (ddif > 0) ? PUSH_LEFT : PUSH_UP_LEFT;
		end else if (tie_lb) begin
			code = (dsum > 0) ? PUSH_DOWN : (dsum < 0) ? PUSH_LEFT : PUSH_DOWN_LEFT;
		end else if (tie_rt) begin
			code = (dsum < 0) ? PUSH_UP : (dsum > 0) ? PUSH_RIGHT : PUSH_UP_RIGHT;
		end else if (tie_rb) begin
			code = (ddif > 0) ? PUSH_DOWN : (ddif < 0) ? PUSH_RIGHT : PUSH_DOWN_RIGHT;
		end

		up_y    = sy_e - mh_e;
		down_y  = sy_e + sh_e;
		left_x  = sx_e - mw_e;
		right_x = sx_e + sw_e;

		move_y_up    = (code == PUSH_UP) || (code == PUSH_UP_LEFT) || (code == PUSH_UP_RIGHT);
		move_y_down  = (code == PUSH_DOWN) || (code == PUSH_DOWN_LEFT)
			|| (code == PUSH_DOWN_RIGHT);
		move_x_left  = (code == PUSH_LEFT) || (code == PUSH_UP_LEFT)
			|| (code == PUSH_DOWN_LEFT);
		move_x_right = (code == PUSH_RIGHT) || (code == PUSH_UP_RIGHT)
			|| (code == PUSH_DOWN_RIGHT);

		ny = (COORD_BITS+1)'(my);
		if (move_y_up)
			ny = up_y[COORD_BITS:0];
		else if (move_y_down)
			ny = down_y[COORD_BITS:0];

		nx = (COORD_BITS+1)'(mx);
		if (move_x_left)
			nx = left_x[COORD_BITS:0];
		else if (move_x_right)
			nx = right_x[COORD_BITS:0];
	end

endmodule

@@ hdl/aabb_push_out_resolver.sv @@
// aabb_push_out_resolver: top level, input register, resolver and result register
// depends on apr_pkg, apr_cfg_regs and apr_resolve
//
// Pushes a moving box out of one configured solid box. One item is taken every
// clock cycle while in_stall is low: the item sits in the input register while the
// resolve logic works on it, and the result register is loaded from that logic once
// it is free or its held result is not stalled.
// The input register also buffers one item while a result is held by out_stall,
// so a full pipeline stalls the input only when both registers are occupied.
// Write the solid box registers only while the block holds no item.
module aabb_push_out_resolver #(
	parameter int COORD_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_we,
	input  logic [apr_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
	input  logic [((COORD_BITS > apr_pkg::SIZE_BITS) ?
		COORD_BITS : apr_pkg::SIZE_BITS)-1:0]             cfg_data,
	input  logic                                          in_valid,
	output logic                                          in_stall,
	input  logic signed [COORD_BITS-1:0]                  mover_x,
	input  logic signed [COORD_BITS-1:0]                  mover_y,
	input  logic signed [COORD_BITS-1:0]                  mover_prev_x,
	input  logic signed [COORD_BITS-1:0]                  mover_prev_y,
	input  logic [apr_pkg::SIZE_BITS-1:0]                 mover_w,
	input  logic [apr_pkg::SIZE_BITS-1:0]                 mover_h,
	input  logic                                          mover_pushable,
	output logic                                          out_valid,
	input  logic                                          out_stall,
	output logic signed [COORD_BITS:0]                    new_x,
	output logic signed [COORD_BITS:0]                    new_y,
	output logic                                          hit,
	output logic [3:0]                                    push_code
);
	import apr_pkg::*;

	localparam int CFG_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;

	logic signed [COORD_BITS-1:0] solid_x, solid_y;
	logic [SIZE_BITS-1:0]         solid_w, solid_h;

	logic                         valid_s1, valid_s2;
	logic signed [COORD_BITS-1:0] mx_s1, my_s1, px_s1, py_s1;
	logic [SIZE_BITS-1:0]         mw_s1, mh_s1;
	logic                         push_s1;
	logic signed [COORD_BITS:0]   nx_c, ny_c;
	push_code_t                   code_c;
	logic signed [COORD_BITS:0]   nx_s2, ny_s2;
	push_code_t                   code_s2;
	logic                         adv_s2, load_s1;

	apr_cfg_regs #(
		.COORD_BITS (COORD_BITS),
		.CFG_BITS   (CFG_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.solid_x   (solid_x),
		.solid_y   (solid_y),
		.solid_w   (solid_w),
		.solid_h   (solid_h)
	);

	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mx_s1   <= mover_x;
			my_s1   <= mover_y;
			px_s1   <= mover_prev_x;
			py_s1   <= mover_prev_y;
			mw_s1   <= mover_w;
			mh_s1   <= mover_h;
			push_s1 <= mover_pushable;
		end
	end

	apr_resolve #(
		.COORD_BITS (COORD_BITS)
	) u_resolve (
		.solid_x  (solid_x),
		.solid_y  (solid_y),
		.solid_w  (solid_w),
		.solid_h  (solid_h),
		.mx       (mx_s1),
		.my       (my_s1),
		.px       (px_s1),
		.py       (py_s1),
		.mw       (mw_s1),
		.mh       (mh_s1),
		.pushable (push_s1),
		.nx       (nx_c),
		.ny       (ny_c),
		.code     (code_c)
	);

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			nx_s2   <= nx_c;
			ny_s2   <= ny_c;
			code_s2 <= code_c;
		end
	end

	assign out_valid = valid_s2;
	assign new_x     = nx_s2;
	assign new_y     = ny_s2;
	assign push_code = code_s2;
	assign hit       = (code_s2 != PUSH_NONE);

	// input held only when both stages are full and the result is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a full pipeline");

	// a buffered item moves to the result register once it is free
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("buffered item did not reach the result register");

	// a result transfer with an empty input stage leaves the result register empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s1) |=> !out_valid)
		else $error("result repeated after transfer");

endmodule

@@ tb/apr_push_checker.sv @@
// apr_push_checker: watches the transfers of aabb_push_out_resolver, predicts each result
// from its own copy of the solid box registers and compares it field by field
// depends on apr_pkg
module apr_push_checker #(
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [apr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [COORD_BITS-1:0]                 cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic signed [COORD_BITS-1:0]          mover_x,
	input  logic signed [COORD_BITS-1:0]          mover_y,
	input  logic signed [COORD_BITS-1:0]          mover_prev_x,
	input  logic signed [COORD_BITS-1:0]          mover_prev_y,
	input  logic [apr_pkg::SIZE_BITS-1:0]         mover_w,
	input  logic [apr_pkg::SIZE_BITS-1:0]         mover_h,
	input  logic                                  mover_pushable,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [COORD_BITS:0]            new_x,
	input  logic signed [COORD_BITS:0]            new_y,
	input  logic                                  hit,
	input  logic [3:0]                            push_code,
	output int                                    fail_count,
	output int                                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import apr_pkg::*;

	typedef struct {
		logic signed [COORD_BITS:0] x;
		logic signed [COORD_BITS:0] y;
		logic                       hit;
		push_code_t                 code;
	} push_result_t;

	longint solid_x, solid_y, solid_w, solid_h;
	push_result_t expected_push_q[$];
	push_result_t want;

	initial fail_count = 0;
	initial outstanding = 0;

	function automatic push_result_t resolve_push(
		input logic signed [COORD_BITS-1:0] cur_x, cur_y, prev_x, prev_y,
		input logic [SIZE_BITS-1:0] size_w, size_h,
		input logic pushable
	);
		longint mx, my, mw, mh, dx, dy, t, r, b, l, nx, ny;
		push_code_t code;
		push_result_t res;
		mx = cur_x;
		my = cur_y;
		mw = size_w;
		mh = size_h;
		dx = mx - longint'(prev_x);
		dy = my - longint'(prev_y);
		nx = mx;
		ny = my;
		code = PUSH_NONE;
		if (pushable) begin
			t = (my + mh - 1) - solid_y;
			r = (solid_x + solid_w - 1) - mx;
			b = (solid_y + solid_h - 1) - my;
			l = (mx + mw - 1) - solid_x;
			if (t > 0 && t < r && t < b && t < l) begin
				code = PUSH_UP;
			end else if (r > 0 && r < t && r < b && r < l) begin
				code = PUSH_RIGHT;
			end else if (b > 0 && b < r && b < t && b < l) begin
				code = PUSH_DOWN;
			end else if (l > 0 && l < r && l < b && l < t) begin
				code = PUSH_LEFT;
			end else if (l > 0 && l == t && l < r && l < b) begin
				code = (dx < dy) ? PUSH_UP : (dx > dy) ? PUSH_LEFT : PUSH_UP_LEFT;
			end else if (l > 0 && l == b && l < r && l < t) begin
				code = (dx > -dy) ? PUSH_DOWN : (dx < -dy) ? PUSH_LEFT : PUSH_DOWN_LEFT;
			end else if (r > 0 && r == t && r < l && r < b) begin
				code = (-dx > dy) ? PUSH_UP : (-dx < dy) ? PUSH_RIGHT : PUSH_UP_RIGHT;
			end else if (r > 0 && r == b && r < l && r < t) begin
				code = (dx > dy) ? PUSH_DOWN : (dx < dy) ? PUSH_RIGHT : PUSH_DOWN_RIGHT;
			end
			if (code inside {PUSH_UP, PUSH_UP_LEFT, PUSH_UP_RIGHT})
				ny = solid_y - mh;
			if (code inside {PUSH_DOWN, PUSH_DOWN_LEFT, PUSH_DOWN_RIGHT})
				ny = solid_y + solid_h;
			if (code inside {PUSH_LEFT, PUSH_UP_LEFT, PUSH_DOWN_LEFT})
				nx = solid_x - mw;
			if (code inside {PUSH_RIGHT, PUSH_UP_RIGHT, PUSH_DOWN_RIGHT})
				nx = solid_x + solid_w;
		end
		res.x = nx[COORD_BITS:0];
		res.y = ny[COORD_BITS:0];
		res.hit = (code != PUSH_NONE);
		res.code = code;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < 40)
			$display("%0t mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			solid_x = 0;
			solid_y = 0;
			solid_w = 1;
			solid_h = 1;
			expected_push_q.delete();
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_SOLID_X: solid_x = longint'($signed(cfg_data));
					REG_SOLID_Y: solid_y = longint'($signed(cfg_data));
					REG_SOLID_W: solid_w = longint'(cfg_data[SIZE_BITS-1:0]);
					REG_SOLID_H: solid_h = longint'(cfg_data[SIZE_BITS-1:0]);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_push_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result x=%0d y=%0d code=%0d",
						new_x, new_y, push_code));
				end else begin
					want = expected_push_q.pop_front();
					if (new_x !== want.x)
						report_mismatch($sformatf("new_x %0d, want %0d", new_x, want.x));
					if (new_y !== want.y)
						report_mismatch($sformatf("new_y %0d, want %0d", new_y, want.y));
					if (hit !== want.hit)
						report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
					if (push_code !== want.code)
						report_mismatch($sformatf("push_code %0d, want %s",
							push_code, want.code.name()));
				end
			end
			if (in_valid && !in_stall)
				expected_push_q.push_back(resolve_push(mover_x, mover_y, mover_prev_x,
					mover_prev_y, mover_w, mover_h, mover_pushable));
		end
		outstanding = expected_push_q.size();
	end

endmodule

@@ tb/testbench.sv @@
// testbench: clock, reset and stimulus for aabb_push_out_resolver, with bursty input
// transfers, a patterned output stall and solid box settings changed between phases
// depends on apr_pkg, aabb_push_out_resolver and apr_push_checker
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import apr_pkg::*;

	localparam int COORD_BITS = 16;

	typedef struct {
		logic signed [COORD_BITS-1:0] x, y, px, py;
		logic [SIZE_BITS-1:0]         w, h;
		logic                         pushable;
	} mover_item_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_SOLID_X;
	logic [COORD_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_BITS-1:0] mover_x = '0, mover_y = '0;
	logic signed [COORD_BITS-1:0] mover_prev_x = '0, mover_prev_y = '0;
	logic [SIZE_BITS-1:0] mover_w = '0, mover_h = '0;
	logic mover_pushable = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_BITS:0] new_x, new_y;
	logic hit;
	logic [3:0] push_code;
	int fail_count, outstanding;

	int stim_sx = 0, stim_sy = 0, stim_sw = 1, stim_sh = 1;
	int burst_left = 0;
	int stall_tick = 0;
	stall_mode_t stall_mode = STALL_NONE;

	aabb_push_out_resolver #(.COORD_BITS(COORD_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mover_x(mover_x), .mover_y(mover_y),
		.mover_prev_x(mover_prev_x), .mover_prev_y(mover_prev_y),
		.mover_w(mover_w), .mover_h(mover_h), .mover_pushable(mover_pushable),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_x(new_x), .new_y(new_y), .hit(hit), .push_code(push_code)
	);

	apr_push_checker #(.COORD_BITS(COORD_BITS)) push_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mover_x(mover_x), .mover_y(mover_y),
		.mover_prev_x(mover_prev_x), .mover_prev_y(mover_prev_y),
		.mover_w(mover_w), .mover_h(mover_h), .mover_pushable(mover_pushable),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_x(new_x), .new_y(new_y), .hit(hit), .push_code(push_code),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always #2 clk = ~clk;

	// receiver stall pattern from a randomly drawn mode: none, light, heavy or periodic
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick[5:0] == 6'd0)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= stall_tick[2];
		endcase
	end

	function automatic mover_item_t pack_item(input int x, y, px, py, w, h, input bit p);
		mover_item_t it;
		it.x = COORD_BITS'(x);
		it.y = COORD_BITS'(y);
		it.px = COORD_BITS'(px);
		it.py = COORD_BITS'(py);
		it.w = SIZE_BITS'(w);
		it.h = SIZE_BITS'(h);
		it.pushable = p;
		return it;
	endfunction

	// mover placed around the solid box, mostly small
	function automatic mover_item_t make_near_item();
		int w, h, x, y;
		w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 48);
		h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 48);
		x = stim_sx - w - 2 + int'($urandom_range(0, stim_sw + w + 4));
		y = stim_sy - h - 2 + int'($urandom_range(0, stim_sh + h + 4));
		return pack_item(x, y, x - int'($urandom_range(0, 24)) + 12,
			y - int'($urandom_range(0, 24)) + 12, w, h, $urandom_range(0, 7) != 0);
	endfunction

	// corner: 0 top-left, 1 bottom-left, 2 top-right, 3 bottom-right
	// rel: 0 motion below the tie line, 1 on it, 2 above it
	function automatic mover_item_t make_corner_item(input int corner, input int rel);
		int d, w, h, x, y, dx, dy, delta;
		d = $urandom_range(1, 6);
		w = $urandom_range(2 * d + 2, 48);
		h = $urandom_range(2 * d + 2, 48);
		x = (corner < 2) ? stim_sx - w + 1 + d : stim_sx + stim_sw - 1 - d;
		y = (corner == 0 || corner == 2) ? stim_sy - h + 1 + d : stim_sy + stim_sh - 1 - d;
		dy = int'($urandom_range(0, 16)) - 8;
		delta = (rel == 1) ? 0 : (rel == 0) ? -int'($urandom_range(1, 4)) :
			int'($urandom_range(1, 4));
		dx = ((corner == 1 || corner == 2) ? -dy : dy) + delta;
		return pack_item(x, y, x - dx, y - dy, w, h, 1'b1);
	endfunction

	task automatic send_item(input mover_item_t it);
		in_valid <= 1'b1;
		mover_x <= it.x;
		mover_y <= it.y;
		mover_prev_x <= it.px;
		mover_prev_y <= it.py;
		mover_w <= it.w;
		mover_h <= it.h;
		mover_pushable <= it.pushable;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) :
				$urandom_range(0, 20);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [COORD_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic write_solid(input int sx, sy, sw, sh);
		logic signed [COORD_BITS-1:0] cx, cy;
		cx = COORD_BITS'(sx);
		cy = COORD_BITS'(sy);
		write_reg(REG_SOLID_X, cx);
		write_reg(REG_SOLID_Y, cy);
		write_reg(REG_SOLID_W, {3'($urandom), SIZE_BITS'(sw)});
		write_reg(REG_SOLID_H, {3'($urandom), SIZE_BITS'(sh)});
		cfg_we <= 1'b0;
		stim_sx = cx;
		stim_sy = cy;
		stim_sw = sw & 8191;
		stim_sh = sh & 8191;
	endtask

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int sx, sy, sw, sh, pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// solid box at its reset setting
		repeat (30) send_item(make_near_item());
		in_valid <= 1'b0;
		drain();

		// directed items against a mid-range box
		write_solid(100, 200, 50, 40);
		send_item(pack_item(120, 198, 120, 194, 4, 4, 1'b1));
		send_item(pack_item(148, 210, 146, 210, 4, 4, 1'b1));
		send_item(pack_item(120, 238, 120, 240, 4, 4, 1'b1));
		send_item(pack_item(98, 210, 95, 210, 4, 4, 1'b1));
		send_item(pack_item(120, 198, 120, 194, 4, 4, 1'b0));
		send_item(pack_item(50, 150, 50, 150, 4, 4, 1'b1));
		send_item(pack_item(100, 200, 100, 200, 50, 40, 1'b1));
		send_item(pack_item(0, 0, 0, 0, 0, 0, 1'b1));
		send_item(pack_item(-1, -1, -1, -1, 8191, 8191, 1'b1));
		send_item(pack_item(32767, -32768, -32768, 32767, 8191, 0, 1'b1));
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 3; r++)
				send_item(make_corner_item(c, r));

		for (int phase = 0; phase < 10; phase++) begin
			in_valid <= 1'b0;
			drain();
			case (phase)
				0: write_solid(-32768, -32768, 1, 1);
				1: write_solid(32767, 32767, 4096, 4096);
				2: write_solid(-32768, 32767, 8191, 8192);
				3: write_solid(32767, -32768, 0, 8191);
				default: begin
					sx = $urandom_range(0, 65535);
					sy = $urandom_range(0, 65535);
					sw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) :
						$urandom_range(1, 200);
					sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) :
						$urandom_range(1, 200);
					write_solid(sx, sy, sw, sh);
				end
			endcase
			for (int i = 0; i < 80; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					send_item(make_near_item());
				else if (pick < 85)
					send_item(make_corner_item($urandom_range(0, 3), $urandom_range(0, 2)));
				else
					send_item(pack_item($urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom_range(0, 1)));
				if ($urandom_range(0, 59) == 0) begin
					in_valid <= 1'b0;
					drain();
				end
			end
		end

		in_valid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/apr_pkg.sv
hdl/apr_cfg_regs.sv
hdl/apr_resolve.sv
hdl/aabb_push_out_resolver.sv
tb/apr_push_checker.sv
tb/testbench.sv
